// ===== rtl/ftoa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftoa_pkg: shared types and constants for the float to decimal text block
// Widths of the fixed-point datapath, character codes, status codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package ftoa_pkg;

    localparam int FLOAT_W             = 32;
    localparam int CHAR_W              = 7;
    localparam int STATUS_W            = 2;
    localparam int DIGIT_W             = 4;
    localparam int INT_DIGITS          = 10;
    localparam int BCD_W               = INT_DIGITS * DIGIT_W;
    localparam int BIN_W               = 31;
    localparam int FRAC_W              = 24;
    localparam int MANT_W              = 24;
    localparam int FIX_W               = 77;
    localparam int FIX_POINT           = 46;
    localparam int SHIFT_W             = 6;
    localparam int STEP_CNT_W          = 5;
    localparam int EXP_W               = 8;
    localparam int NDIG_W              = 4;

    localparam int TEXT_BUFFER_BYTES   = 15;
    localparam int MAX_FRACTION_DIGITS = 7;
    localparam int RESULT_LIMIT        = 13;

    localparam logic [EXP_W-1:0]      EXP_TOO_LARGE = 8'd158;
    localparam logic [EXP_W-1:0]      EXP_MIN       = 8'd104;
    localparam logic [STEP_CNT_W-1:0] DABBLE_LAST   = 5'(BIN_W - 1);
    localparam logic [NDIG_W-1:0]     NDIG_FULL     = 4'(INT_DIGITS);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_TOO_SMALL = 2'd2
    } t_status;

    typedef enum logic {
        OP_DABBLE,
        OP_TIMES10
    } t_step_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DABBLE,
        S_NORM,
        S_FRAC,
        S_SIGN,
        S_INT,
        S_POINT,
        S_FDIG,
        S_ERR
    } t_state;

endpackage : ftoa_pkg
`default_nettype wire

// ===== rtl/ftoa_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftoa_in_if: input channel
// Valid/ready channel that carries one single-precision bit pattern.
// ----------------------------------------------------------------------------
interface ftoa_in_if;
    import ftoa_pkg::*;

    logic               valid;
    logic               ready;
    logic [FLOAT_W-1:0] float_bits;

    modport source (output valid, output float_bits, input ready);
    modport sink   (input valid, input float_bits, output ready);

endinterface : ftoa_in_if
`default_nettype wire

// ===== rtl/ftoa_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftoa_out_if: output channel
// Valid/ready channel that carries one text character with status and last.
// ----------------------------------------------------------------------------
interface ftoa_out_if;
    import ftoa_pkg::*;

    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   character;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, output character, output status, output last, input ready);
    modport sink   (input valid, input character, input status, input last, output ready);

endinterface : ftoa_out_if
`default_nettype wire

// ===== rtl/ftoa_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftoa_step: shared arithmetic step
// One double-dabble shift-and-adjust step for the integer part, or one
// multiply-by-ten step that yields the next fraction digit.
// ----------------------------------------------------------------------------
module ftoa_step
    import ftoa_pkg::*;
(
    input  var t_step_op           i_op,
    input  var logic [BCD_W-1:0]   i_bcd,
    input  var logic [BIN_W-1:0]   i_bin,
    input  var logic [FRAC_W-1:0]  i_frac,
    output var logic [BCD_W-1:0]   o_bcd,
    output var logic [BIN_W-1:0]   o_bin,
    output var logic [FRAC_W-1:0]  o_frac,
    output var logic [DIGIT_W-1:0] o_digit
);

    logic [BCD_W-1:0]          adj;
    logic [FRAC_W+DIGIT_W-1:0] prod;

    always_comb begin
        adj     = i_bcd;
        prod    = '0;
        o_bcd   = i_bcd;
        o_bin   = i_bin;
        o_frac  = i_frac;
        o_digit = '0;
        unique case (i_op)
            OP_DABBLE: begin
                for (int k = 0; k < INT_DIGITS; k++) begin
                    if (i_bcd[k*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                        adj[k*DIGIT_W +: DIGIT_W] = i_bcd[k*DIGIT_W +: DIGIT_W] + 4'd3;
                    end
                end
                o_bcd = {adj[BCD_W-2:0], i_bin[BIN_W-1]};
                o_bin = {i_bin[BIN_W-2:0], 1'b0};
            end
            OP_TIMES10: begin
                prod    = {1'b0, i_frac, 3'b000} + {3'b000, i_frac, 1'b0};
                o_frac  = prod[FRAC_W-1:0];
                o_digit = prod[FRAC_W+DIGIT_W-1:FRAC_W];
            end
        endcase
    end

endmodule : ftoa_step
`default_nettype wire

// ===== rtl/float_to_decimal_text.sv =====
`timescale 1ns / 1ps
`default_nettype none
// After one transfer in, the double-dabble steps and then the fraction steps
// run on the shared step unit, with leading zero digits dropped between them;
// then one character per cycle goes out while the sink is ready. An error
// input gives its single result through the error state and output register.
// A new input is taken only in idle, after the last character is pushed.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// float_to_decimal_text: single-precision float to decimal ASCII text
// Converts an IEEE 754 bit pattern to sign, integer digits, point and
// truncated fraction digits, one character per output transfer.
// ----------------------------------------------------------------------------
module float_to_decimal_text
    import ftoa_pkg::*;
#(
    parameter int MAX_FRACTION_DIGITS_P = MAX_FRACTION_DIGITS
) (
    input  var logic   i_clk,
    input  var logic   i_rst_n,
    ftoa_in_if.sink    i_in,
    ftoa_out_if.source o_out
);

    localparam int FCW = $clog2(MAX_FRACTION_DIGITS_P + 1);
    localparam logic [FCW-1:0] FCNT_LAST = FCW'(MAX_FRACTION_DIGITS_P - 1);
    localparam logic [FCW-1:0] FKEEP_MIN = FCW'(1);

    function automatic int frac_budget(input logic neg, input logic [NDIG_W-1:0] ndig);
        int len;
        int b;
        len = int'(neg) + int'(ndig) + 1;
        b   = MAX_FRACTION_DIGITS_P;
        if (TEXT_BUFFER_BYTES - len - 1 < b) begin
            b = TEXT_BUFFER_BYTES - len - 1;
        end
        if (RESULT_LIMIT - len < b) begin
            b = RESULT_LIMIT - len;
        end
        if (b < 1) begin
            b = 1;
        end
        return b;
    endfunction

    t_state                r_state, n_state;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic [BIN_W-1:0]      r_bin, n_bin;
    logic [FRAC_W-1:0]     r_frac, n_frac;
    logic [MAX_FRACTION_DIGITS_P-1:0][DIGIT_W-1:0] r_fdig, n_fdig;
    logic                  r_neg, n_neg;
    t_status               r_err, n_err;
    logic [NDIG_W-1:0]     r_ndig, n_ndig;
    logic [STEP_CNT_W-1:0] r_cnt, n_cnt;
    logic [FCW-1:0]        r_fcnt, n_fcnt;
    logic [FCW-1:0]        r_fkeep, n_fkeep;

    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_out_char;
    t_status               r_out_status;
    logic                  r_out_last;

    logic                  push;
    logic [CHAR_W-1:0]     push_char;
    t_status               push_status;
    logic                  push_last;
    logic                  out_free;

    t_step_op              step_op;
    logic [BCD_W-1:0]      step_bcd;
    logic [BIN_W-1:0]      step_bin;
    logic [FRAC_W-1:0]     step_frac;
    logic [DIGIT_W-1:0]    step_digit;

    logic [EXP_W-1:0]      in_exp;
    logic [MANT_W-1:0]     in_mant;
    logic [SHIFT_W-1:0]    in_shift;
    logic [FIX_W-1:0]      in_fix;
    logic                  in_zero;
    int                    budget;

    assign out_free = !r_out_valid || o_out.ready;
    assign budget   = frac_budget(r_neg, r_ndig);

    assign in_exp   = i_in.float_bits[30:23];
    assign in_mant  = i_in.float_bits[MANT_W-1:0] | 24'h800000;
    assign in_shift = SHIFT_W'(in_exp - EXP_MIN);
    assign in_fix   = FIX_W'(in_mant) << in_shift;
    assign in_zero  = (i_in.float_bits[30:0] == 31'd0);

    assign i_in.ready = (r_state == S_IDLE);

    ftoa_step u_step (
        .i_op    (step_op),
        .i_bcd   (r_bcd),
        .i_bin   (r_bin),
        .i_frac  (r_frac),
        .o_bcd   (step_bcd),
        .o_bin   (step_bin),
        .o_frac  (step_frac),
        .o_digit (step_digit)
    );

    always_comb begin
        n_state     = r_state;
        n_bcd       = r_bcd;
        n_bin       = r_bin;
        n_frac      = r_frac;
        n_fdig      = r_fdig;
        n_neg       = r_neg;
        n_err       = r_err;
        n_ndig      = r_ndig;
        n_cnt       = r_cnt;
        n_fcnt      = r_fcnt;
        n_fkeep     = r_fkeep;
        step_op     = OP_DABBLE;
        push        = 1'b0;
        push_char   = CH_NUL;
        push_status = ST_OK;
        push_last   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_fcnt  = '0;
                    n_fkeep = FKEEP_MIN;
                    n_ndig  = NDIG_FULL;
                    n_neg   = i_in.float_bits[31] && !in_zero;
                    priority if (in_zero) begin
                        n_bin   = '0;
                        n_frac  = '0;
                        n_state = S_DABBLE;
                    end else if (in_exp >= EXP_TOO_LARGE) begin
                        n_err   = ST_TOO_LARGE;
                        n_state = S_ERR;
                    end else if (in_exp < EXP_MIN) begin
                        n_err   = ST_TOO_SMALL;
                        n_state = S_ERR;
                    end else begin
                        n_bin   = in_fix[FIX_W-1:FIX_POINT];
                        n_frac  = in_fix[FIX_POINT-1:FIX_POINT-FRAC_W];
                        n_state = S_DABBLE;
                    end
                end
            end
            S_DABBLE: begin
                step_op = OP_DABBLE;
                n_bcd   = step_bcd;
                n_bin   = step_bin;
                n_cnt   = r_cnt + 5'd1;
                if (r_cnt == DABBLE_LAST) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (r_ndig > 4'd1 && r_bcd[BCD_W-1 -: DIGIT_W] == 4'd0) begin
                    n_bcd  = {r_bcd[BCD_W-DIGIT_W-1:0], 4'd0};
                    n_ndig = r_ndig - 4'd1;
                end else begin
                    n_state = S_FRAC;
                end
            end
            S_FRAC: begin
                step_op = OP_TIMES10;
                n_frac  = step_frac;
                for (int k = 0; k < MAX_FRACTION_DIGITS_P - 1; k++) begin
                    n_fdig[k] = r_fdig[k+1];
                end
                n_fdig[MAX_FRACTION_DIGITS_P-1] = step_digit;
                if (int'(r_fcnt) < budget && step_digit != 4'd0) begin
                    n_fkeep = r_fcnt + FKEEP_MIN;
                end
                n_fcnt = r_fcnt + FKEEP_MIN;
                if (r_fcnt == FCNT_LAST) begin
                    n_state = r_neg ? S_SIGN : S_INT;
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_char = CH_MINUS;
                    n_state   = S_INT;
                end
            end
            S_INT: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_char = CH_ZERO + CHAR_W'(r_bcd[BCD_W-1 -: DIGIT_W]);
                    n_bcd     = {r_bcd[BCD_W-DIGIT_W-1:0], 4'd0};
                    n_ndig    = r_ndig - 4'd1;
                    if (r_ndig == 4'd1) begin
                        n_state = S_POINT;
                    end
                end
            end
            S_POINT: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_char = CH_POINT;
                    n_state   = S_FDIG;
                end
            end
            S_FDIG: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_char = CH_ZERO + CHAR_W'(r_fdig[0]);
                    push_last = (r_fkeep == FKEEP_MIN);
                    for (int k = 0; k < MAX_FRACTION_DIGITS_P - 1; k++) begin
                        n_fdig[k] = r_fdig[k+1];
                    end
                    n_fdig[MAX_FRACTION_DIGITS_P-1] = '0;
                    n_fkeep = r_fkeep - FKEEP_MIN;
                    if (r_fkeep == FKEEP_MIN) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    push        = 1'b1;
                    push_char   = CH_NUL;
                    push_status = r_err;
                    push_last   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd   <= n_bcd;
        r_bin   <= n_bin;
        r_frac  <= n_frac;
        r_fdig  <= n_fdig;
        r_neg   <= n_neg;
        r_err   <= n_err;
        r_ndig  <= n_ndig;
        r_cnt   <= n_cnt;
        r_fcnt  <= n_fcnt;
        r_fkeep <= n_fkeep;
        if (push) begin
            r_out_char   <= push_char;
            r_out_status <= push_status;
            r_out_last   <= push_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_out_char;
    assign o_out.status    = r_out_status;
    assign o_out.last      = r_out_last;

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != ST_OK |-> o_out.last && o_out.character == CH_NUL)
        else $error("error result must be a single final NUL");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input accepted while a conversion is running");

    a_int_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INT |-> r_ndig != 4'd0)
        else $error("integer digit count ran out");

    a_fkeep_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FDIG |-> r_fkeep != '0)
        else $error("fraction digit count ran out");

endmodule : float_to_decimal_text
`default_nettype wire

// ===== test/float_to_decimal_text_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_to_decimal_text_tb: self-checking bench for float to decimal text
// Feeds single-precision bit patterns over the input channel, computes the
// expected character string for each transfer and checks every character,
// status and last flag in order. Directed zero, sign, exponent range and
// fraction cases come first, then random patterns under random gaps,
// a long output stall and a stretch at full rate.
// ----------------------------------------------------------------------------
module float_to_decimal_text_tb;
    import ftoa_pkg::*;

    localparam int          CLK_PERIOD        = 10;
    localparam int          RESET_CYCLES      = 10;
    localparam int          SINK_HOLD_CYCLES  = 400;
    localparam int          END_CYCLES        = 80;
    localparam int unsigned TIMEOUT_NS        = 2_000_000;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        t_status           status;
        logic              last;
    } t_text_char;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ftoa_in_if  in_ch ();
    ftoa_out_if text_ch ();

    t_text_char expected_text[$];
    int         mismatches = 0;
    bit         sender_idle = 1'b1;
    bit         sink_idle = 1'b1;
    bit         sink_hold_request = 1'b0;

    float_to_decimal_text uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (text_ch.source)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void push_text_char(input logic [CHAR_W-1:0] ch, input t_status st,
                                           input logic last);
        t_text_char item;
        item.character = ch;
        item.status    = st;
        item.last      = last;
        expected_text.insert(expected_text.size(), item);
    endfunction

    function automatic void predict_text(input logic [FLOAT_W-1:0] bits);
        logic [CHAR_W-1:0] txt [0:15];
        logic [3:0]        digit_buf [0:11];
        logic [63:0]       mant;
        logic [63:0]       whole;
        logic [63:0]       frac;
        logic [63:0]       rem;
        int                exponent;
        int                len;
        int                n;
        int                budget;
        len   = 0;
        whole = '0;
        frac  = '0;
        if (bits[30:0] == '0) begin
            txt[0] = CH_ZERO;
            txt[1] = CH_POINT;
            txt[2] = CH_ZERO;
            len    = 3;
        end else begin
            exponent = int'(bits[30:23]) - 127;
            if (exponent >= 31) begin
                push_text_char(CH_NUL, ST_TOO_LARGE, 1'b1);
                return;
            end
            if (exponent < -23) begin
                push_text_char(CH_NUL, ST_TOO_SMALL, 1'b1);
                return;
            end
            mant = {40'd0, 1'b1, bits[22:0]};
            if (exponent >= 23) begin
                whole = mant << (exponent - 23);
            end else if (exponent >= 0) begin
                whole = mant >> (23 - exponent);
                frac  = mant << (exponent + 1);
                frac[63:FRAC_W] = '0;
            end else begin
                frac = mant >> (-1 - exponent);
            end
            if (bits[31]) begin
                txt[len] = CH_MINUS;
                len++;
            end
            if (whole == 0) begin
                txt[len] = CH_ZERO;
                len++;
            end else begin
                n = 0;
                while (whole != 0) begin
                    rem          = whole % 64'd10;
                    digit_buf[n] = rem[3:0];
                    whole        = whole / 64'd10;
                    n++;
                end
                while (n > 0) begin
                    n--;
                    txt[len] = CH_ZERO + {3'b000, digit_buf[n]};
                    len++;
                end
            end
            txt[len] = CH_POINT;
            len++;
            if (frac == 0) begin
                txt[len] = CH_ZERO;
                len++;
            end else begin
                budget = TEXT_BUFFER_BYTES - len - 1;
                if (budget > MAX_FRACTION_DIGITS) begin
                    budget = MAX_FRACTION_DIGITS;
                end
                if (budget > RESULT_LIMIT - len) begin
                    budget = RESULT_LIMIT - len;
                end
                if (budget < 1) begin
                    budget = 1;
                end
                for (int m = 0; m < budget; m++) begin
                    frac     = frac * 64'd10;
                    txt[len] = CH_ZERO + {3'b000, frac[FRAC_W+3:FRAC_W]};
                    frac[63:FRAC_W] = '0;
                    len++;
                end
                while (len >= 2 && txt[len-1] == CH_ZERO && txt[len-2] != CH_POINT) begin
                    len--;
                end
            end
        end
        for (int k = 0; k < len; k++) begin
            push_text_char(txt[k], ST_OK, k == len - 1);
        end
    endfunction

    function automatic logic [FLOAT_W-1:0] random_float();
        logic [7:0] biased;
        int         pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            return {1'($urandom_range(0, 1)), 31'd0};
        end else if (pick <= 2) begin
            return $urandom();
        end else if (pick <= 4) begin
            case ($urandom_range(0, 5))
                0:       biased = 8'h00;
                1:       biased = 8'hFF;
                2:       biased = EXP_TOO_LARGE;
                3:       biased = EXP_TOO_LARGE - 8'd1;
                4:       biased = EXP_MIN;
                default: biased = EXP_MIN - 8'd1;
            endcase
        end else begin
            biased = 8'($urandom_range(int'(EXP_MIN), int'(EXP_TOO_LARGE) - 1));
        end
        return {1'($urandom_range(0, 1)), biased, 23'($urandom())};
    endfunction

    task automatic send_float(input logic [FLOAT_W-1:0] bits);
        int gap;
        gap = sender_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.float_bits <= bits;
        do begin
            @(posedge i_clk);
        end while (in_ch.ready !== 1'b1);
        predict_text(bits);
    endtask

    task automatic wait_for_text();
        in_ch.valid <= 1'b0;
        while (expected_text.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_zero_and_sign();
        send_float(32'h0000_0000);
        send_float(32'h8000_0000);
        send_float(32'h3F80_0000);
        send_float(32'hBF80_0000);
        send_float(32'hBF00_0000);
        send_float(32'h4000_0000);
    endtask

    task automatic test_exponent_range();
        send_float(32'h7F80_0000);
        send_float(32'hFF80_0000);
        send_float(32'h7FC0_0000);
        send_float(32'h4F00_0000);
        send_float(32'h4EFF_FFFF);
        send_float(32'hCEFF_FFFF);
        send_float(32'h3400_0000);
        send_float(32'hB4FF_FFFF);
        send_float(32'h33FF_FFFF);
        send_float(32'h0000_0001);
        send_float(32'h807F_FFFF);
        send_float(32'h7F7F_FFFF);
    endtask

    task automatic test_fraction_digits();
        send_float(32'h3DCC_CCCD);
        send_float(32'h3EAA_AAAB);
        send_float(32'hCAFF_FFFF);
        send_float(32'h4B7F_FFFF);
        send_float(32'h3FFF_FFFF);
        send_float(32'h42F6_E979);
    endtask

    task automatic test_random_values(input int count);
        repeat (count) send_float(random_float());
    endtask

    task automatic test_output_stall(input int count);
        sink_hold_request = 1'b1;
        repeat (count) send_float(random_float());
    endtask

    task automatic test_full_rate(input int count);
        sender_idle = 1'b0;
        sink_idle   = 1'b0;
        repeat (count) send_float(random_float());
        sender_idle = 1'b1;
        sink_idle   = 1'b1;
    endtask

    initial begin
        int wait_cycles;
        text_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) begin
            @(posedge i_clk);
        end
        forever begin
            if (sink_hold_request) begin
                sink_hold_request = 1'b0;
                text_ch.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                wait_cycles = sink_idle ? $urandom_range(0, 3) : 0;
                if (wait_cycles > 0) begin
                    text_ch.ready <= 1'b0;
                    repeat (wait_cycles) @(posedge i_clk);
                end
            end
            text_ch.ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (text_ch.valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n === 1'b1 && text_ch.valid === 1'b1 && text_ch.ready === 1'b1) begin
            if (expected_text.size() == 0) begin
                $display("%0t: unexpected transfer: expected none, actual %0d/%0d/%0d",
                         $time, text_ch.character, text_ch.status, text_ch.last);
                mismatches++;
            end else begin
                want = expected_text.pop_front();
                if (text_ch.character !== want.character) begin
                    $display("%0t: character mismatch: expected %0d actual %0d",
                             $time, want.character, text_ch.character);
                    mismatches++;
                end
                if (text_ch.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, text_ch.status);
                    mismatches++;
                end
                if (text_ch.last !== want.last) begin
                    $display("%0t: last mismatch: expected %0d actual %0d",
                             $time, want.last, text_ch.last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.float_bits <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_and_sign();
        test_exponent_range();
        test_fraction_digits();
        wait_for_text();
        test_random_values(200);
        wait_for_text();
        test_output_stall(20);
        test_full_rate(40);
        wait_for_text();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_text.size() == 0) begin
            $display("[float_to_decimal_text] OK");
        end else begin
            $display("[float_to_decimal_text] ERROR");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d characters outstanding", $time, expected_text.size());
        $display("[float_to_decimal_text] ERROR");
        $finish;
    end

endmodule : float_to_decimal_text_tb

// ===== float_to_decimal_text.f =====
rtl/ftoa_pkg.sv
rtl/ftoa_in_if.sv
rtl/ftoa_out_if.sv
rtl/ftoa_step.sv
rtl/float_to_decimal_text.sv
test/float_to_decimal_text_tb.sv
